// ===== rtl/core/glf_pkg.sv =====
// Package for the Gaussian line fraction core.
// Holds pipeline types, fixed-point constants and the tail probability ROM.
`default_nettype none
package glf_pkg;
	localparam int TableSteps = 60;
	localparam int FracBits   = 16;
	localparam int QuoBits    = 22;
	localparam int RemBits    = 54;
	localparam int DenBits    = 31;
	localparam int IdxBits    = 6;
	localparam int RomBits    = 17;

	typedef struct packed {
		logic                 vld;
		logic                 oor;
		logic [RemBits-1:0]   rem;
		logic [DenBits-1:0]   den;
		logic [QuoBits-1:0]   quo;
	} div_t;

	function automatic logic [RomBits-1:0] tail_rom(input logic [IdxBits-1:0] idx);
		logic [RomBits-1:0] v;
		case (idx)
			6'd0: v = 17'd65536;  6'd1: v = 17'd62923;  6'd2: v = 17'd60316;
			6'd3: v = 17'd57722;  6'd4: v = 17'd55147;  6'd5: v = 17'd52598;
			6'd6: v = 17'd50081;  6'd7: v = 17'd47601;  6'd8: v = 17'd45165;
			6'd9: v = 17'd42776;  6'd10: v = 17'd40441; 6'd11: v = 17'd38163;
			6'd12: v = 17'd35947; 6'd13: v = 17'd33796; 6'd14: v = 17'd31715;
			6'd15: v = 17'd29705; 6'd16: v = 17'd27768; 6'd17: v = 17'd25908;
			6'd18: v = 17'd24125; 6'd19: v = 17'd22421; 6'd20: v = 17'd20795;
			6'd21: v = 17'd19249; 6'd22: v = 17'd17782; 6'd23: v = 17'd16393;
			6'd24: v = 17'd15082; 6'd25: v = 17'd13848; 6'd26: v = 17'd12688;
			6'd27: v = 17'd11601; 6'd28: v = 17'd10585; 6'd29: v = 17'd9638;
			6'd30: v = 17'd8757;  6'd31: v = 17'd7939;  6'd32: v = 17'd7183;
			6'd33: v = 17'd6484;  6'd34: v = 17'd5841;  6'd35: v = 17'd5251;
			6'd36: v = 17'd4709;  6'd37: v = 17'd4215;  6'd38: v = 17'd3764;
			6'd39: v = 17'd3354;  6'd40: v = 17'd2982;  6'd41: v = 17'd2645;
			6'd42: v = 17'd2342;  6'd43: v = 17'd2068;  6'd44: v = 17'd1822;
			6'd45: v = 17'd1602;  6'd46: v = 17'd1406;  6'd47: v = 17'd1230;
			6'd48: v = 17'd1074;  6'd49: v = 17'd936;   6'd50: v = 17'd814;
			6'd51: v = 17'd706;   6'd52: v = 17'd611;   6'd53: v = 17'd528;
			6'd54: v = 17'd454;   6'd55: v = 17'd391;   6'd56: v = 17'd335;
			6'd57: v = 17'd287;   6'd58: v = 17'd245;   6'd59: v = 17'd208;
			6'd60: v = 17'd177;
			default: v = '0;
		endcase
		return v;
	endfunction
endpackage
`default_nettype wire

// ===== rtl/core/glf_front.sv =====
// First stage: distance magnitude, width check, range check and numerator scaling.
// Depends on glf_pkg.
`default_nettype none
module glf_front (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         en,
	input  wire logic         in_vld,
	input  wire logic [31:0]  energy,
	input  wire logic [31:0]  line_centre,
	input  wire logic [31:0]  line_width,
	output glf_pkg::div_t     div_s1
);
	logic signed [32:0] diff;
	logic [32:0] mag;
	logic [37:0] scaled;
	logic [33:0] lim;
	logic        oor;

	always_comb begin
		diff   = {energy[31], energy} - {line_centre[31], line_centre};
		mag    = diff[32] ? 33'(-diff) : 33'(diff);
		scaled = {1'b0, mag, 4'b0} + {3'b0, mag, 2'b0};
		lim    = {line_width[31], line_width, 1'b0} + {{2{line_width[31]}}, line_width};
		oor    = line_width[31] || (line_width == '0) || ({1'b0, mag} >= lim);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_s1 <= '0;
		end else if (en) begin
			div_s1.vld <= in_vld;
			div_s1.oor <= oor;
			div_s1.rem <= {scaled, 16'b0};
			div_s1.den <= line_width[30:0];
			div_s1.quo <= '0;
		end
	end
endmodule
`default_nettype wire

// ===== rtl/core/glf_div_stage.sv =====
// One restoring division step that resolves a single quotient bit.
// Depends on glf_pkg.
`default_nettype none
module glf_div_stage #(
	parameter int BIT = 0
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          en,
	input  wire glf_pkg::div_t d_in,
	output glf_pkg::div_t      d_out
);
	logic [glf_pkg::RemBits-1:0] sub;
	logic                        take;
	glf_pkg::div_t               nxt;

	always_comb begin
		sub          = glf_pkg::RemBits'(d_in.den) << BIT;
		take         = d_in.rem >= sub;
		nxt          = d_in;
		nxt.rem      = take ? d_in.rem - sub : d_in.rem;
		nxt.quo[BIT] = take;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			d_out <= '0;
		end else if (en) begin
			d_out <= nxt;
		end
	end
endmodule
`default_nettype wire

// ===== rtl/core/glf_interp.sv =====
// Table lookup, linear interpolation and final complement, two register stages.
// Depends on glf_pkg.
`default_nettype none
module glf_interp (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          en,
	input  wire glf_pkg::div_t d_in,
	output logic               vld_s3,
	output logic [15:0]        fraction_s3,
	output logic               oor_s3
);
	logic [5:0]  idx;
	logic [16:0] f_lo, f_hi;
	logic [33:0] p0_s2, p1_s2;
	logic        vld_s2, oor_s2;
	logic [34:0] acc;

	always_comb begin
		idx  = d_in.quo[21:16];
		f_hi = {1'b0, d_in.quo[15:0]};
		f_lo = 17'd65536 - f_hi;
		acc  = {1'b0, p0_s2} + {1'b0, p1_s2} + 35'd32768;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s2 <= d_in.vld;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			oor_s2      <= d_in.oor;
			p0_s2       <= f_lo * glf_pkg::tail_rom(idx);
			p1_s2       <= f_hi * glf_pkg::tail_rom(idx + 6'd1);
			oor_s3      <= oor_s2;
			fraction_s3 <= oor_s2 ? 16'd0 : 16'(17'd65536 - acc[32:16]);
		end
	end
endmodule
`default_nettype wire

// ===== rtl/core/gaussian_line_fraction_core.sv =====
// Gaussian line fraction core.
// Input transfers carry energy, line centre and line width; each gives one result.
// The sigma ratio is scaled and divided one quotient bit per pipeline stage.
// A 61-entry tail probability ROM is interpolated by the fractional position.
// Depends on glf_pkg, glf_front, glf_div_stage and glf_interp.
// The slave channel takes one transfer per cycle while s_tready is high;
// s_tdata holds energy, line_centre and line_width from the lowest bit up.
// The master channel returns fraction in m_tdata and out_of_range in m_tuser.
// The pipeline has one front stage, 22 division stages and two
// interpolation stages. Throughput is one item per cycle unless the output stalls.
// The whole pipeline advances together; when the receiver holds m_tready low
// with a result waiting, every stage holds and s_tready drops.
// Reset clears all stage valid bits, so no result appears until new input.
// Widths of zero or less, and distances of three widths or more, return
// fraction zero with out_of_range set.
`default_nettype none
module gaussian_line_fraction_core (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [95:0] s_tdata,   // energy, line_centre, line_width
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [15:0]      m_tdata,   // fraction
	output logic             m_tuser    // out_of_range
);
	logic          en;
	glf_pkg::div_t chain [glf_pkg::QuoBits+1];

	assign en       = !m_tvalid || m_tready;
	assign s_tready = en;

	glf_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.en          (en),
		.in_vld      (s_tvalid),
		.energy      (s_tdata[31:0]),
		.line_centre (s_tdata[63:32]),
		.line_width  (s_tdata[95:64]),
		.div_s1      (chain[0])
	);

	for (genvar k = 0; k < glf_pkg::QuoBits; k++) begin : g_div
		glf_div_stage #(.BIT(glf_pkg::QuoBits - 1 - k)) u_stage (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.d_in   (chain[k]),
			.d_out  (chain[k+1])
		);
	end

	glf_interp u_interp (
		.clk         (clk),
		.arst_n      (arst_n),
		.en          (en),
		.d_in        (chain[glf_pkg::QuoBits]),
		.vld_s3      (m_tvalid),
		.fraction_s3 (m_tdata),
		.oor_s3      (m_tuser)
	);
endmodule
`default_nettype wire

// ===== dv/gaussian_line_fraction_core_tb.sv =====
// Testbench for gaussian_line_fraction_core: random and directed stream transfers
// checked in order against a behavioral line-fraction predictor.
// Depends on the RTL core and its package glf_pkg.
`default_nettype none
module gaussian_line_fraction_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [15:0] fraction;
		logic        oor;
	} frac_res_t;

	class fraction_board;
		frac_res_t pending[$];
		int        mismatches;
		int        checked;
		int unsigned tail[61];

		function new();
			tail = '{65536, 62923, 60316, 57722, 55147, 52598, 50081, 47601,
				45165, 42776, 40441, 38163, 35947, 33796, 31715, 29705,
				27768, 25908, 24125, 22421, 20795, 19249, 17782, 16393,
				15082, 13848, 12688, 11601, 10585, 9638, 8757, 7939,
				7183, 6484, 5841, 5251, 4709, 4215, 3764, 3354,
				2982, 2645, 2342, 2068, 1822, 1602, 1406, 1230,
				1074, 936, 814, 706, 611, 528, 454, 391,
				335, 287, 245, 208, 177};
		endfunction

		function frac_res_t line_fraction(logic signed [31:0] e, logic signed [31:0] c,
			logic signed [31:0] w);
			frac_res_t r;
			longint signed diff;
			longint unsigned d, den, num, idx, rem, f, acc, inter;
			r.fraction = '0;
			r.oor = 1'b1;
			if (w <= 0)
				return r;
			diff = longint'(e) - longint'(c);
			d = (diff < 0) ? -diff : diff;
			den = 3 * longint'(w);
			num = d * 60;
			idx = num / den;
			if (idx >= 60)
				return r;
			rem = num % den;
			f = (rem << 16) / den;
			acc = (65536 - f) * tail[idx] + f * tail[idx + 1];
			inter = (acc + 32768) >> 16;
			r.fraction = 16'(65536 - inter);
			r.oor = 1'b0;
			return r;
		endfunction

		function void note_input(logic [95:0] data);
			pending.push_back(line_fraction(data[31:0], data[63:32], data[95:64]));
		endfunction

		function void check_result(logic [15:0] fraction, logic oor);
			frac_res_t exp_r;
			checked++;
			if (pending.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("Unexpected result: fraction %0d oor %0b", fraction, oor);
				return;
			end
			exp_r = pending.pop_front();
			if (exp_r.fraction !== fraction || exp_r.oor !== oor) begin
				mismatches++;
				if (mismatches <= 10)
					$display("Mismatch: expected fraction %0d oor %0b, got %0d oor %0b",
						exp_r.fraction, exp_r.oor, fraction, oor);
			end
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [95:0] s_tdata = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [15:0] m_tdata;
	logic        m_tuser;

	fraction_board board = new();
	int  send_idle = 0;
	int  recv_idle = 0;
	bit  hold_off = 1'b0;
	int  quiet = 0;
	int  sent = 0;

	gaussian_line_fraction_core i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always #2 clk = ~clk;

	always @(posedge clk) begin
		if (s_tvalid && s_tready)
			board.note_input(s_tdata);
		if (m_tvalid && m_tready)
			board.check_result(m_tdata, m_tuser);
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			quiet <= 0;
		else
			quiet <= quiet + 1;
	end

	always @(posedge clk) begin
		if (quiet > 5000) begin
			$display("Watchdog: no transfer for %0d cycles", quiet);
			$display("gaussian_line_fraction_core_tb failed");
			$finish;
		end
	end

	always @(negedge clk) begin
		if (!arst_n || hold_off)
			m_tready <= 1'b0;
		else
			m_tready <= ($urandom_range(99) >= recv_idle);
	end

	task automatic send_item(logic [31:0] e, logic [31:0] c, logic [31:0] w);
		while ($urandom_range(99) < send_idle) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {w, c, e};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		sent++;
		@(negedge clk);
	endtask

	task automatic send_random();
		logic [31:0] e, c, w;
		int unsigned k;
		k = $urandom_range(9);
		e = $urandom();
		c = $urandom();
		w = $urandom();
		if (k < 7) begin
			w = $urandom_range(32'h7fff_ffff, 1) >> $urandom_range(30);
			if (w == 0)
				w = 1;
			c = $urandom() >> $urandom_range(31);
			e = c + 32'((((longint'(w) * 3 * longint'($urandom_range(1100))) / 1000)
				* ($urandom_range(1) ? 1 : -1)));
		end else if (k == 7) begin
			w = -($urandom() >> $urandom_range(31));
		end
		send_item(e, c, w);
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		while (board.pending.size() != 0)
			@(negedge clk);
		repeat (40) @(negedge clk);
	endtask

	initial begin
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		send_item(32'h0001_0000, 32'h0001_0000, 32'h0001_0000);
		send_item(32'h0001_0000, 32'h0000_0000, 32'h0000_0000);
		send_item(32'h0001_0000, 32'h0000_0000, 32'h8000_0000);
		send_item(32'hffff_ffff, 32'h0000_0000, 32'h0000_0001);
		send_item(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff);
		send_item(32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff);
		send_item(32'h0003_0000, 32'h0000_0000, 32'h0001_0000);
		send_item(32'h0002_ffff, 32'h0000_0000, 32'h0001_0000);
		send_item(32'h0000_0000, 32'h0002_ffff, 32'h0001_0000);
		send_item(32'h0000_0ccd, 32'h0000_0000, 32'h0001_0000);
		send_item(32'h7fff_ffff, 32'h7fff_ffff, 32'h0000_0001);
		send_item(32'h0000_0000, 32'h0000_0000, 32'hffff_ffff);
		send_item(32'h0000_8000, 32'hffff_8000, 32'h0000_8000);
		drain();
		for (int phase = 0; phase < 3; phase++) begin
			send_idle = (phase == 0) ? 12 : (phase == 1) ? 62 : 0;
			recv_idle = (phase == 0) ? 62 : (phase == 1) ? 12 : 0;
			for (int n = 0; n < 630; n++) begin
				if (phase == 0 && n == 200)
					fork
						begin
							hold_off = 1'b1;
							repeat (80) @(negedge clk);
							hold_off = 1'b0;
						end
					join_none
				if (n == 400)
					drain();
				send_random();
			end
		end
		drain();
		$display("Sent %0d items and checked %0d results, including invalid widths,",
			sent, board.checked);
		$display("table-end distances and a long receiver stall.");
		if (board.mismatches == 0 && board.pending.size() == 0)
			$display("gaussian_line_fraction_core_tb passed");
		else
			$display("gaussian_line_fraction_core_tb failed");
		$finish;
	end
endmodule
`default_nettype wire

// ===== gaussian_line_fraction_core.f =====
rtl/core/glf_pkg.sv
rtl/core/glf_front.sv
rtl/core/glf_div_stage.sv
rtl/core/glf_interp.sv
rtl/core/gaussian_line_fraction_core.sv
dv/gaussian_line_fraction_core_tb.sv
